[rtl/core/rmsp_pkg.sv]
// Shared widths, register indexes and formats of the RMSProp update block.
`timescale 1ns / 1ps
package rmsp_pkg;

	// element store
	localparam int ELEMENT_DEPTH = 4096;
	localparam int ELEM_AW       = $clog2(ELEMENT_DEPTH);

	// data formats
	localparam int DATA_W = 24;    // Q8.16 words
	localparam int CFG_W  = 16;    // configuration word
	localparam int CFG_IW = 2;     // configuration index
	localparam int MUL_W  = 24;    // multiplier operand width
	localparam int PROD_W = 2 * MUL_W;
	localparam int SUB_W  = 40;    // compare-subtract width

	// configuration register indexes
	localparam logic [CFG_IW-1:0] REG_LEARNING_RATE = 2'd0;
	localparam logic [CFG_IW-1:0] REG_DECAY_RATE    = 2'd1;
	localparam logic [CFG_IW-1:0] REG_BATCH_SIZE    = 2'd2;

	// result of the shared compare-subtract unit
	typedef struct packed {
		logic [SUB_W-1:0] diff;
		logic             ge;
	} sub_res_t;

endpackage

[rtl/core/rmsp_mul.sv]
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps
module rmsp_mul import rmsp_pkg::*; (
	input  logic              clk,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] p_q
);

	// one product per cycle, result registered
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

[rtl/core/rmsp_sub.sv]
// Shared compare-subtract step used by the square root and the divider.
`timescale 1ns / 1ps
module rmsp_sub import rmsp_pkg::*; (
	input  logic [SUB_W-1:0] a,
	input  logic [SUB_W-1:0] b,
	output sub_res_t         res
);

	logic [SUB_W:0] d;

	// borrow out clear means a >= b
	always_comb begin
		d        = {1'b0, a} - {1'b0, b};
		res.diff = d[SUB_W-1:0];
		res.ge   = ~d[SUB_W];
	end

endmodule

[rtl/core/rmsp_ms_mem.sv]
// Mean-square store: one write and one registered read port, cleared after reset.
`timescale 1ns / 1ps
module rmsp_ms_mem import rmsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ELEM_AW-1:0] rd_addr,
	output logic [DATA_W-1:0]  rd_data,
	input  logic               wr_en,
	input  logic [ELEM_AW-1:0] wr_addr,
	input  logic [DATA_W-1:0]  wr_data,
	output logic               clr_busy
);

	logic [DATA_W-1:0] mem [ELEMENT_DEPTH];
	logic [ELEM_AW:0]  clr_cnt_q;

	assign clr_busy = ~clr_cnt_q[ELEM_AW];

	// clearing pass counter, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clr_busy) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (clr_busy) begin
			mem[clr_cnt_q[ELEM_AW-1:0]] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/core/rmsprop_weight_update.sv]
// RMSProp weight update: sequencer around a shared multiplier and compare-subtract unit.
// One word in flight at a time. The 21-step square root and the 33-step divide run
// on the shared compare-subtract unit; each word also makes six multiplier passes.
// Reset: configuration and control registers take their defaults; a clearing pass
// over all 4096 entries of the mean-square store follows, during which in_ready
// stays low (config is taken).
`timescale 1ns / 1ps
module rmsprop_weight_update import rmsp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IW-1:0]        cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [11:0]              element_index,
	input  logic signed [DATA_W-1:0] gradient,
	input  logic signed [DATA_W-1:0] weight_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] weight_out,
	output logic                     saturated
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MDM   = 4'd1;
	localparam logic [3:0] ST_MGL   = 4'd2;
	localparam logic [3:0] ST_MGH   = 4'd3;
	localparam logic [3:0] ST_MS    = 4'd4;
	localparam logic [3:0] ST_RND   = 4'd5;
	localparam logic [3:0] ST_SQRT  = 4'd6;
	localparam logic [3:0] ST_DEN   = 4'd7;
	localparam logic [3:0] ST_DWAIT = 4'd8;
	localparam logic [3:0] ST_DIV   = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	localparam int SQRT_STEPS = 21;
	localparam int DIV_STEPS  = 33;
	localparam logic [DATA_W-1:0] MS_MAX = '1;

	// configuration registers
	logic [CFG_W-1:0] lr_q, decay_q, batch_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q    <= 16'd66;
			decay_q <= 16'd58982;
			batch_q <= 16'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LEARNING_RATE: lr_q    <= cfg_data;
				REG_DECAY_RATE:    decay_q <= cfg_data;
				REG_BATCH_SIZE:    batch_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control and datapath registers
	logic [3:0]               state_q;
	logic [5:0]               cnt_q;
	logic [ELEM_AW-1:0]       idx_q;
	logic                     gneg_q;
	logic [DATA_W-1:0]        gmag_q;
	logic signed [DATA_W-1:0] w_q;
	logic [PROD_W-1:0]        gsq_q;
	logic [63:0]              acc_q;
	logic                     sat_q;
	logic [39:0]              pnum_q;
	logic [41:0]              nsh_q;
	logic [SUB_W-1:0]         rem_q;
	logic [20:0]              root_q;
	logic [37:0]              dv_q;
	logic [DIV_STEPS-1:0]     quo_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] wout_q;
	logic                     osat_q;

	// shared units
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod;
	logic [SUB_W-1:0]  sub_a, sub_b;
	sub_res_t          sub_r;
	logic [DATA_W-1:0] ms_rd;
	logic              clr_busy;
	logic              mem_we;
	logic [DATA_W-1:0] ms_new;

	logic              in_fire;
	logic [DATA_W-1:0] gmag_in;
	logic [16:0]       one_m_d;
	logic [CFG_W-1:0]  batch_eff;
	logic [32:0]       ms_rnd;
	logic              ms_ovf;
	logic [40:0]       div_n;
	logic signed [34:0] res_w;
	logic              out_free;

	assign in_ready  = (state_q == ST_IDLE) && !clr_busy;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign weight_out = wout_q;
	assign saturated = osat_q;
	assign out_free  = !out_valid_q || out_ready;

	assign gmag_in   = gradient[DATA_W-1] ? DATA_W'(-gradient) : DATA_W'(gradient);
	assign one_m_d   = 17'h10000 - {1'b0, decay_q};
	assign batch_eff = (batch_q == '0) ? CFG_W'(1) : batch_q;

	// rounded mean square and its clamp
	assign ms_rnd = 33'((acc_q + 64'h8000_0000) >> 32);
	assign ms_ovf = ms_rnd > {9'd0, MS_MAX};
	assign ms_new = ms_ovf ? MS_MAX : ms_rnd[DATA_W-1:0];
	assign mem_we = (state_q == ST_RND);

	// divider numerator 2*pnum + den
	assign div_n = {pnum_q, 1'b0} + prod[40:0];

	// updated weight before clamp
	assign res_w = gneg_q ? (35'(w_q) + $signed({2'b0, quo_q}))
	                      : (35'(w_q) - $signed({2'b0, quo_q}));

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_IDLE: begin
				mul_a = gmag_in;
				mul_b = gmag_in;
			end
			ST_MDM: begin
				mul_a = MUL_W'(decay_q);
				mul_b = ms_rd;
			end
			ST_MGL: begin
				mul_a = MUL_W'(one_m_d);
				mul_b = gsq_q[23:0];
			end
			ST_MGH: begin
				mul_a = MUL_W'(one_m_d);
				mul_b = gsq_q[47:24];
			end
			ST_MS: begin
				mul_a = MUL_W'(lr_q);
				mul_b = gmag_q;
			end
			ST_DEN: begin
				mul_a = MUL_W'(batch_eff);
				mul_b = MUL_W'(root_q);
			end
			default: ;
		endcase
	end

	// compare-subtract operand select: root step or divide step
	always_comb begin
		if (state_q == ST_SQRT) begin
			sub_a = {rem_q[37:0], nsh_q[41:40]};
			sub_b = {17'd0, root_q, 2'b01};
		end else begin
			sub_a = {rem_q[38:0], nsh_q[32]};
			sub_b = {2'b0, dv_q};
		end
	end

	rmsp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	rmsp_sub u_sub (
		.a   (sub_a),
		.b   (sub_b),
		.res (sub_r)
	);

	rmsp_ms_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (element_index[ELEM_AW-1:0]),
		.rd_data  (ms_rd),
		.wr_en    (mem_we),
		.wr_addr  (idx_q),
		.wr_data  (ms_new),
		.clr_busy (clr_busy)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:  if (in_fire) state_q <= ST_MDM;
				ST_MDM:   state_q <= ST_MGL;
				ST_MGL:   state_q <= ST_MGH;
				ST_MGH:   state_q <= ST_MS;
				ST_MS:    state_q <= ST_RND;
				ST_RND: begin
					state_q <= ST_SQRT;
					cnt_q   <= 6'(SQRT_STEPS - 1);
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_DEN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DEN:   state_q <= ST_DWAIT;
				ST_DWAIT: begin
					state_q <= ST_DIV;
					cnt_q   <= 6'(DIV_STEPS - 1);
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					idx_q  <= element_index[ELEM_AW-1:0];
					gneg_q <= gradient[DATA_W-1];
					gmag_q <= gmag_in;
					w_q    <= weight_in;
				end
			end
			ST_MDM: gsq_q <= prod;
			ST_MGL: acc_q <= {prod, 16'd0};
			ST_MGH: acc_q <= acc_q + {16'd0, prod};
			ST_MS:  acc_q <= acc_q + {prod[39:0], 24'd0};
			ST_RND: begin
				// start root of (ms + 1) * 2^16
				pnum_q <= prod[39:0];
				sat_q  <= ms_ovf;
				nsh_q  <= {1'b0, ({1'b0, ms_new} + 25'd1), 16'd0};
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				rem_q  <= sub_r.ge ? sub_r.diff : sub_a;
				root_q <= {root_q[19:0], sub_r.ge};
				nsh_q  <= {nsh_q[39:0], 2'b00};
			end
			ST_DWAIT: begin
				// divide (2*pnum + den) by 2*den
				dv_q  <= {prod[36:0], 1'b0};
				rem_q <= {32'd0, div_n[40:33]};
				nsh_q <= {9'd0, div_n[32:0]};
			end
			ST_DIV: begin
				rem_q <= sub_r.ge ? sub_r.diff : sub_a;
				quo_q <= {quo_q[DIV_STEPS-2:0], sub_r.ge};
				nsh_q <= {nsh_q[40:0], 1'b0};
			end
			ST_OUT: begin
				if (out_free) begin
					if (res_w > 35'sd8388607) begin
						wout_q <= 24'sh7FFFFF;
						osat_q <= 1'b1;
					end else if (res_w < -35'sd8388608) begin
						wout_q <= 24'sh800000;
						osat_q <= 1'b1;
					end else begin
						wout_q <= res_w[DATA_W-1:0];
						osat_q <= sat_q;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

[tb/sv/rmsprop_weight_update_test.sv]
// Self-checking testbench for the RMSProp weight update block.
`timescale 1ns / 1ps
module rmsprop_weight_update_test;
	import rmsp_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 80;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASE_ITEMS = 190;

	typedef struct {
		logic signed [DATA_W-1:0] weight;
		logic                     sat;
	} update_t;

	typedef struct {
		logic [11:0]              idx;
		logic signed [DATA_W-1:0] grad;
		logic signed [DATA_W-1:0] w;
		bit                       typed;
		update_t                  res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [11:0] element_index = '0;
	logic signed [DATA_W-1:0] gradient = '0;
	logic signed [DATA_W-1:0] weight_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DATA_W-1:0] weight_out;
	logic saturated;

	// predictor state
	bit [23:0] ms_store [ELEMENT_DEPTH];
	bit [15:0] lr_q, decay_q, batch_q;
	update_t   pending_updates [$];
	row_t      directed_rows [$];
	int        fail_count = 0;
	int        cycle_count = 0;
	bit        hold_req = 0;
	bit        no_gaps = 0;

	rmsprop_weight_update DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic bit [63:0] int_sqrt(input bit [63:0] n);
		bit [63:0] root;
		bit [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// mean-square update then weight step; updates the store copy
	function automatic update_t rms_predict(input logic [11:0] idx,
			input logic signed [DATA_W-1:0] g, input logic signed [DATA_W-1:0] w);
		update_t   r;
		longint    gi, wi, res;
		bit [63:0] gm, num, ms, root, den, pnum, step, bdiv;
		int        a;
		a = idx % ELEMENT_DEPTH;
		gi = g;
		wi = w;
		r.sat = 1'b0;
		gm = (gi < 0) ? -gi : gi;
		num = 64'(decay_q) * 64'(ms_store[a]) * 64'd65536
			+ (64'd65536 - 64'(decay_q)) * (gm * gm);
		ms = (num + (64'd1 << 31)) >> 32;
		if (ms > 64'hFFFFFF) begin
			ms = 64'hFFFFFF;
			r.sat = 1'b1;
		end
		ms_store[a] = ms[23:0];
		root = int_sqrt((ms + 1) << 16);
		bdiv = (batch_q == 0) ? 64'd1 : 64'(batch_q);
		den = bdiv * root;
		pnum = 64'(lr_q) * gm;
		step = (2 * pnum + den) / (2 * den);
		res = (gi < 0) ? wi + longint'(step) : wi - longint'(step);
		if (res > 8388607) begin
			res = 8388607;
			r.sat = 1'b1;
		end else if (res < -8388608) begin
			res = -8388608;
			r.sat = 1'b1;
		end
		r.weight = res[23:0];
		return r;
	endfunction

	function automatic int gap_len();
		if (no_gaps)
			return 0;
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(20, 120);
	endfunction

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input bit [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LEARNING_RATE: lr_q = val;
			REG_DECAY_RATE:    decay_q = val;
			REG_BATCH_SIZE:    batch_q = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_updates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_config(input bit [15:0] lr, input bit [15:0] dr, input bit [15:0] bs);
		write_reg(REG_LEARNING_RATE, lr);
		write_reg(REG_DECAY_RATE, dr);
		write_reg(REG_BATCH_SIZE, bs);
	endtask

	// offer one word; valid stays high into the next word when there is no gap
	task automatic send_word(input row_t r, input bit last);
		update_t p;
		int      gap;
		in_valid <= 1'b1;
		element_index <= r.idx;
		gradient <= r.grad;
		weight_in <= r.w;
		do @(posedge clk); while (!in_ready);
		p = rms_predict(r.idx, r.grad, r.w);
		pending_updates.push_back(r.typed ? r.res : p);
		gap = last ? 1 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic add_row(input logic [11:0] idx, input int g, input int w,
			input bit typed, input int wo, input bit sat);
		row_t r;
		r.idx = idx;
		r.grad = DATA_W'(g);
		r.w = DATA_W'(w);
		r.typed = typed;
		r.res.weight = DATA_W'(wo);
		r.res.sat = sat;
		directed_rows.push_back(r);
	endtask

	function automatic row_t random_row();
		row_t r;
		r.typed = 0;
		r.idx = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 15)) : 12'($urandom);
		case ($urandom_range(0, 3))
			0: r.grad = 24'($urandom);
			1: r.grad = DATA_W'($signed(24'($urandom_range(0, 2047))) - 1024);
			2: r.grad = 0;
			default: r.grad = DATA_W'($signed(24'($urandom_range(0, 262143))) - 131072);
		endcase
		r.w = 24'($urandom);
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		update_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_updates.size() == 0) begin
				$error("unexpected word: weight_out=%0d saturated=%0b", weight_out, saturated);
				fail_count++;
			end else begin
				e = pending_updates.pop_front();
				if (weight_out !== e.weight) begin
					$error("weight_out: expected %0d, actual %0d", e.weight, weight_out);
					fail_count++;
				end
				if (saturated !== e.sat) begin
					$error("saturated: expected %0b, actual %0b", e.sat, saturated);
					fail_count++;
				end
			end
		end
	end

	// receiver backpressure
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
			end else if (no_gaps) begin
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 29) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(20, 120)) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// main sequence
	initial begin
		int i, p;
		bit [15:0] lr_set [6], dr_set [6], bs_set [6];
		lr_set = '{16'd65535, 16'd65535, 16'd0, 16'd1000, 16'd0, 16'd65535};
		dr_set = '{16'd0, 16'd65535, 16'd32768, 16'd60000, 16'd0, 16'd58982};
		bs_set = '{16'd1, 16'd0, 16'd65535, 16'd4, 16'd0, 16'd1};
		lr_set[4] = 16'($urandom);
		dr_set[4] = 16'($urandom);
		bs_set[4] = 16'($urandom);
		for (i = 0; i < ELEMENT_DEPTH; i++)
			ms_store[i] = 0;
		lr_q = 66;
		decay_q = 58982;
		batch_q = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings; zero gradient passes the weight
		add_row(12'd0, 0, 0, 1, 0, 0);
		add_row(12'd4095, 0, 8388607, 1, 8388607, 0);
		add_row(12'd1, 0, -8388608, 1, -8388608, 0);
		add_row(12'd2, 8388607, 0, 0, 0, 0);
		add_row(12'd3, -8388608, 0, 0, 0, 0);
		add_row(12'd2, 0, 1234, 1, 1234, 0);
		add_row(12'd4, 8388607, -8388608, 0, 0, 0);
		add_row(12'd5, -8388608, 8388607, 0, 0, 0);
		add_row(12'd6, 1, 0, 0, 0, 0);
		add_row(12'd6, -1, 0, 0, 0, 0);
		add_row(12'd7, 65536, 65536, 0, 0, 0);
		add_row(12'd7, 65536, 65536, 0, 0, 0);
		add_row(12'd7, -65536, -65536, 0, 0, 0);
		add_row(12'd4095, 100, -100, 0, 0, 0);
		add_row(12'd8, 0, -1, 1, -1, 0);
		foreach (directed_rows[i])
			send_word(directed_rows[i], i == directed_rows.size() - 1);
		in_valid <= 1'b0;

		// random phases over several register settings
		for (p = 0; p < 6; p++) begin
			wait_idle();
			set_config(lr_set[p], dr_set[p], bs_set[p]);
			no_gaps = (p == 3);
			if (p == 1)
				hold_req = 1;
			for (i = 0; i < PHASE_ITEMS; i++)
				send_word(random_row(), i == PHASE_ITEMS - 1);
			in_valid <= 1'b0;
		end
		no_gaps = 0;

		wait_idle();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
